// ===== rtl/multi_led_blink_timer_assert.svh =====
// Assertion macros shared by the checker of the LED blink timer.
`ifndef MULTI_LED_BLINK_TIMER_ASSERT_SVH
`define MULTI_LED_BLINK_TIMER_ASSERT_SVH

// Clocked assertion that is ignored while reset is asserted.
`define MLBT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define MLBT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/mlbt_pkg.sv =====
// Package with shared constants, command codes and the channel state type.
`timescale 1ns / 1ps
`default_nettype none

package mlbt_pkg;

    localparam int NUM_LEDS = 8;
    localparam int CH_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int MASK_W   = 8;
    localparam int TIME_W   = 16;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic [TIME_W-1:0] cycle_target;
        logic [TIME_W-1:0] phase_count;
        logic [TIME_W-1:0] cycles_done;
        logic              in_off_phase;
        logic              enabled;
        logic              lit;
    } chan_t;

endpackage

`default_nettype wire

// ===== rtl/mlbt_tick_unit.sv =====
// Shared tick step that advances the state of one channel by one tick.
`timescale 1ns / 1ps
`default_nettype none

module mlbt_tick_unit
    import mlbt_pkg::*;
(
    input  wire chan_t  cur,
    input  wire logic   muted,
    output chan_t       nxt
);

    logic [TIME_W-1:0] phase_inc;
    logic [TIME_W-1:0] done_inc;

    assign phase_inc = cur.phase_count + TIME_W'(1);
    assign done_inc  = cur.cycles_done + TIME_W'(1);

    always_comb begin
        nxt = cur;
        if (cur.enabled && (cur.off_time != '0) && !muted) begin
            nxt.phase_count = phase_inc;
            if (!cur.in_off_phase) begin
                if (phase_inc >= cur.on_time) begin
                    nxt.lit          = 1'b0;
                    nxt.phase_count  = '0;
                    nxt.in_off_phase = 1'b1;
                end
            end else if (phase_inc >= cur.off_time) begin
                if ((cur.cycle_target != '0) && (done_inc >= cur.cycle_target)) begin
                    nxt.cycles_done = done_inc;
                    nxt.enabled     = 1'b0;
                    nxt.off_time    = '0;
                end else begin
                    if (cur.cycle_target != '0) begin
                        nxt.cycles_done = done_inc;
                    end
                    nxt.phase_count  = '0;
                    nxt.in_off_phase = 1'b0;
                    nxt.lit          = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/multi_led_blink_timer.sv =====
// Top level: channel state registers, command sequencer and result register.
// A tick word visits one channel per cycle through a shared tick unit, and
// start, stop and no-op words pass the command state; the response state then
// registers the result. The next word is accepted in the cycle after it is taken.
// Synchronous active-low reset clears all channels (LEDs dark, all disabled)
// and the mute mask; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module multi_led_blink_timer
    import mlbt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [MASK_W-1:0] cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_cmd,
    input  wire logic [2:0]        s_led_index,
    input  wire logic [TIME_W-1:0] s_on_ticks,
    input  wire logic [TIME_W-1:0] s_off_ticks,
    input  wire logic [TIME_W-1:0] s_cycle_limit,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [MASK_W-1:0]      m_led_on_mask,
    output logic [MASK_W-1:0]      m_active_mask
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_CMD  = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_LEDS - 1);

    logic [1:0]        state_reg, state_next;
    logic [CH_W-1:0]   idx_reg, idx_next;
    logic              idx_ok_reg, idx_ok_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [TIME_W-1:0] on_reg, on_next;
    logic [TIME_W-1:0] off_reg, off_next;
    logic [TIME_W-1:0] lim_reg, lim_next;
    logic [MASK_W-1:0] mute_reg, mute_next;
    chan_t             chan_reg [NUM_LEDS];
    chan_t             chan_next [NUM_LEDS];
    logic              m_valid_reg, m_valid_next;
    logic [MASK_W-1:0] lmask_reg, lmask_next;
    logic [MASK_W-1:0] amask_reg, amask_next;

    logic [NUM_LEDS-1:0] mute_vec;
    logic [NUM_LEDS-1:0] lit_vec;
    logic [NUM_LEDS-1:0] en_vec;
    chan_t               cur_chan;
    chan_t               tick_chan;
    logic                cur_muted;
    logic                accept;

    assign s_ready       = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_led_on_mask = lmask_reg;
    assign m_active_mask = amask_reg;

    always_comb begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            mute_vec[i] = (i < MASK_W) ? mute_reg[i % MASK_W] : 1'b0;
            lit_vec[i]  = chan_reg[i].lit;
            en_vec[i]   = chan_reg[i].enabled;
        end
    end

    assign cur_chan  = chan_reg[idx_reg];
    assign cur_muted = mute_vec[idx_reg];

    mlbt_tick_unit u_tick (
        .cur   (cur_chan),
        .muted (cur_muted),
        .nxt   (tick_chan)
    );

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        idx_ok_next  = idx_ok_reg;
        cmd_next     = cmd_reg;
        on_next      = on_reg;
        off_next     = off_reg;
        lim_next     = lim_reg;
        mute_next    = cfg_we ? cfg_wdata : mute_reg;
        chan_next    = chan_reg;
        m_valid_next = m_valid_reg && !m_ready;
        lmask_next   = lmask_reg;
        amask_next   = amask_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next    = s_cmd;
                    on_next     = s_on_ticks;
                    off_next    = s_off_ticks;
                    lim_next    = s_cycle_limit;
                    idx_ok_next = 32'(s_led_index) < NUM_LEDS;
                    if (s_cmd == CMD_TICK) begin
                        idx_next   = '0;
                        state_next = ST_TICK;
                    end else begin
                        idx_next   = CH_W'(s_led_index);
                        state_next = ST_CMD;
                    end
                end
            end
            ST_TICK: begin
                chan_next[idx_reg] = tick_chan;
                if (idx_reg == LAST_CH) begin
                    state_next = ST_RESP;
                end else begin
                    idx_next = idx_reg + CH_W'(1);
                end
            end
            ST_CMD: begin
                if (idx_ok_reg) begin
                    case (cmd_reg)
                        CMD_START: begin
                            if ((on_reg != '0) && !cur_muted) begin
                                chan_next[idx_reg].on_time      = on_reg;
                                chan_next[idx_reg].off_time     = off_reg;
                                chan_next[idx_reg].cycle_target = lim_reg;
                                chan_next[idx_reg].phase_count  = '0;
                                chan_next[idx_reg].cycles_done  = '0;
                                chan_next[idx_reg].in_off_phase = 1'b0;
                                chan_next[idx_reg].enabled      = 1'b1;
                                chan_next[idx_reg].lit          = 1'b1;
                            end
                        end
                        CMD_STOP: begin
                            chan_next[idx_reg].enabled = 1'b0;
                            if ((cur_chan.off_time == '0) || (cur_chan.cycle_target == '0)) begin
                                chan_next[idx_reg].lit = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                m_valid_next = 1'b1;
                for (int i = 0; i < MASK_W; i++) begin
                    lmask_next[i] = (i < NUM_LEDS) ? lit_vec[i % NUM_LEDS] : 1'b0;
                    amask_next[i] = (i < NUM_LEDS) ? en_vec[i % NUM_LEDS] : 1'b0;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            mute_reg    <= '0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                chan_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            mute_reg    <= mute_next;
            chan_reg    <= chan_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_ok_reg <= idx_ok_next;
        cmd_reg    <= cmd_next;
        on_reg     <= on_next;
        off_reg    <= off_next;
        lim_reg    <= lim_next;
        lmask_reg  <= lmask_next;
        amask_reg  <= amask_next;
    end

endmodule

`default_nettype wire

// ===== rtl/mlbt_checker.sv =====
// Port-level checker for the LED blink timer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_led_blink_timer_assert.svh"

module mlbt_checker
    import mlbt_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [MASK_W-1:0] m_led_on_mask,
    input wire logic [MASK_W-1:0] m_active_mask
);

    // A stalled result word keeps its value until it is taken.
    `MLBT_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_led_on_mask) && $stable(m_active_mask), "result word changed while stalled")

    // No new word is taken while a result is still pending.
    `MLBT_ASSERT(a_no_overlap, !(s_ready && m_valid), "input ready while a result is pending")

    // An accepted word keeps the block busy in the following cycle.
    `MLBT_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready again right after acceptance")

    // A delivered result is never repeated.
    `MLBT_ASSERT(a_single_result, m_valid && m_ready |=> !m_valid, "result repeated after handshake")

    // Reset leaves no result pending.
    `MLBT_ASSERT_RST(a_reset_clear, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind multi_led_blink_timer mlbt_checker u_mlbt_checker (.*);

`default_nettype wire
